FILE: rtl/lossw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid line-of-sight walker.
// No dependencies; imported by every module of the block.
package lossw_pkg;

	localparam int COORD_W = 6;
	localparam int COORD_SPAN = 1 << COORD_W;
	localparam int GRID_WIDTH_DEF = 64;
	localparam int GRID_HEIGHT_DEF = 64;

	// error term |d| stays below (2*63+1)*63, so 15 bits two's complement
	localparam int DIST_W = 15;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic visible;
	} walk_status_t;

endpackage

FILE: rtl/lossw_map.sv
`timescale 1ns / 1ps
// Blocked-cell map: one synchronous row memory, bit writes, registered row read.
// Runs a row-by-row clearing pass after reset. Depends on lossw_pkg.
module lossw_map #(
	parameter int GRID_WIDTH = lossw_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lossw_pkg::GRID_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lossw_pkg::coord_t wr_x,
	input  lossw_pkg::coord_t wr_y,
	input  logic            wr_val,
	input  logic            rd_en,
	input  lossw_pkg::coord_t rd_x,
	input  lossw_pkg::coord_t rd_y,
	output logic            rd_bit,
	output logic            clr_busy
);
	import lossw_pkg::*;

	// coordinates never exceed the field range, so cells beyond it need no storage
	localparam int COLS = (GRID_WIDTH < COORD_SPAN) ? GRID_WIDTH : COORD_SPAN;
	localparam int ROWS = (GRID_HEIGHT < COORD_SPAN) ? GRID_HEIGHT : COORD_SPAN;
	localparam int COL_AW = $clog2(COLS);
	localparam int ROW_AW = $clog2(ROWS);
	localparam logic [COORD_W:0] COLS_C = (COORD_W + 1)'(COLS);
	localparam logic [COORD_W:0] ROWS_C = (COORD_W + 1)'(ROWS);
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

	logic [COLS-1:0] mem [ROWS];
	logic [COLS-1:0] row_s1;
	logic [COL_AW-1:0] rx_s1;
	logic in_s1;
	logic [ROW_AW-1:0] clr_row_q;
	logic clr_busy_q;
	logic wr_in;
	logic rd_in;

	assign wr_in = ({1'b0, wr_x} < COLS_C) && ({1'b0, wr_y} < ROWS_C);
	assign rd_in = ({1'b0, rd_x} < COLS_C) && ({1'b0, rd_y} < ROWS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == LAST_ROW) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (wr_en && wr_in) begin
			mem[wr_y[ROW_AW-1:0]][wr_x[COL_AW-1:0]] <= wr_val;
		end
	end

	// cells outside the grid read as free
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1 <= mem[rd_y[ROW_AW-1:0]];
			rx_s1 <= rd_x[COL_AW-1:0];
			in_s1 <= rd_in;
		end
	end

	assign rd_bit = in_s1 && row_s1[rx_s1];
	assign clr_busy = clr_busy_q;

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && clr_busy_q)) else $error("cell write during clearing pass");
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && clr_busy_q)) else $error("map read during clearing pass");
	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_row_q) == LAST_ROW)
		else $error("clearing pass ended early");

endmodule

FILE: rtl/lossw_walk.sv
`timescale 1ns / 1ps
// Walk sequencer: steps the grid line one cell per cycle, reads each cell from
// the map and stops at the first blocked cell. Depends on lossw_pkg.
module lossw_walk (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  lossw_pkg::coord_t      src_x,
	input  lossw_pkg::coord_t      src_y,
	input  lossw_pkg::coord_t      dst_x,
	input  lossw_pkg::coord_t      dst_y,
	input  logic                   take,
	output logic                   rd_en,
	output lossw_pkg::coord_t      rd_x,
	output lossw_pkg::coord_t      rd_y,
	input  logic                   rd_bit,
	output lossw_pkg::walk_status_t status
);
	import lossw_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	coord_t px_q, py_q, ix_q, iy_q, nx_q, ny_q;
	logic neg_x_q, neg_y_q;
	logic [DIST_W-1:0] d_q;
	logic chk_s1;
	logic vis_q;

	logic at_end, hit, issue, fin;
	logic step_x, step_y;
	coord_t px_n, py_n, nx_in, ny_in;
	logic [DIST_W-1:0] two_nx, two_ny, d_n;

	assign nx_in = (dst_x >= src_x) ? dst_x - src_x : src_x - dst_x;
	assign ny_in = (dst_y >= src_y) ? dst_y - src_y : src_y - dst_y;

	assign at_end = (ix_q == nx_q) && (iy_q == ny_q);
	assign hit = chk_s1 && rd_bit;
	assign fin = (state_q == ST_RUN) && (hit || at_end);
	assign issue = (state_q == ST_RUN) && !hit && !at_end;

	// d = 0: diagonal, d < 0: y only, d > 0: x only
	assign step_y = d_q[DIST_W-1] || (d_q == '0);
	assign step_x = !d_q[DIST_W-1];

	assign px_n = step_x ? (neg_x_q ? px_q - 1'b1 : px_q + 1'b1) : px_q;
	assign py_n = step_y ? (neg_y_q ? py_q - 1'b1 : py_q + 1'b1) : py_q;

	assign two_nx = {{(DIST_W - COORD_W - 1){1'b0}}, nx_q, 1'b0};
	assign two_ny = {{(DIST_W - COORD_W - 1){1'b0}}, ny_q, 1'b0};
	assign d_n = d_q + (step_y ? two_nx : '0) - (step_x ? two_ny : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (fin) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			px_q <= src_x;
			py_q <= src_y;
			ix_q <= '0;
			iy_q <= '0;
			nx_q <= nx_in;
			ny_q <= ny_in;
			neg_x_q <= dst_x < src_x;
			neg_y_q <= dst_y < src_y;
			d_q <= {{(DIST_W - COORD_W){1'b0}}, nx_in} - {{(DIST_W - COORD_W){1'b0}}, ny_in};
		end else if (issue) begin
			px_q <= px_n;
			py_q <= py_n;
			ix_q <= ix_q + {{(COORD_W - 1){1'b0}}, step_x};
			iy_q <= iy_q + {{(COORD_W - 1){1'b0}}, step_y};
			d_q <= d_n;
		end
		if (fin) begin
			vis_q <= !hit;
		end
	end

	assign rd_en = issue;
	assign rd_x = px_n;
	assign rd_y = py_n;

	assign status.busy = state_q != ST_IDLE;
	assign status.done = state_q == ST_HOLD;
	assign status.visible = vis_q;

	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && hit) |=> (state_q == ST_HOLD && !vis_q))
		else $error("blocked cell did not end the walk");
	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (ix_q <= nx_q && iy_q <= ny_q))
		else $error("walk stepped past the destination");
	a_check_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> $past(rd_en) && state_q == ST_RUN)
		else $error("cell check without a read");

endmodule

FILE: rtl/grid_line_of_sight_walker.sv
`timescale 1ns / 1ps
// Top level of the grid line-of-sight walker: request intake, map, walker and
// result register. Depends on lossw_pkg, lossw_map and lossw_walk.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | req_valid req_stall req_type cell_* src_* dst_* | in
//  result  | rsp_valid rsp_stall visible               | out
//
// A cell write gives no result.
// A query walks at most 125 cells on a 64 by 64 grid; the map's single row read
// per cycle sets the pace.
// After reset a clearing pass of min(GRID_HEIGHT, 64) rows runs; req_stall
// stays high until it ends, while a query is in progress and while a finished
// query waits for a stalled result register to free.
// A held result sits in the result register; the next request is taken meanwhile.
module grid_line_of_sight_walker #(
	parameter int GRID_WIDTH = lossw_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lossw_pkg::GRID_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              req_type,
	input  lossw_pkg::coord_t cell_x,
	input  lossw_pkg::coord_t cell_y,
	input  logic              cell_blocked,
	input  lossw_pkg::coord_t src_x,
	input  lossw_pkg::coord_t src_y,
	input  lossw_pkg::coord_t dst_x,
	input  lossw_pkg::coord_t dst_y,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              visible
);
	import lossw_pkg::*;

	logic clr_busy;
	logic accept, wr_en, start, take;
	logic rd_en, rd_bit;
	coord_t rd_x, rd_y;
	walk_status_t wstat;
	logic rsp_valid_q, visible_q;

	assign req_stall = clr_busy || wstat.busy;
	assign accept = req_valid && !req_stall;
	assign wr_en = accept && (req_type == REQ_WRITE);
	assign start = accept && (req_type == REQ_QUERY);

	// result register frees when empty or when its transfer completes
	assign take = wstat.done && (!rsp_valid_q || !rsp_stall);

	lossw_map #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_x(cell_x),
		.wr_y(cell_y),
		.wr_val(cell_blocked),
		.rd_en(rd_en),
		.rd_x(rd_x),
		.rd_y(rd_y),
		.rd_bit(rd_bit),
		.clr_busy(clr_busy)
	);

	lossw_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.src_x(src_x),
		.src_y(src_y),
		.dst_x(dst_x),
		.dst_y(dst_y),
		.take(take),
		.rd_en(rd_en),
		.rd_x(rd_x),
		.rd_y(rd_y),
		.rd_bit(rd_bit),
		.status(wstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			visible_q <= wstat.visible;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign visible = visible_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_line_of_sight_walker: directed and random cell writes and
// line-of-sight queries checked against an in-bench walk of the grid.
// Depends on lossw_pkg and the RTL top level only.
module testbench;
	import lossw_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1500;

	typedef struct {
		logic   rtype;
		coord_t cx;
		coord_t cy;
		logic   cb;
		coord_t sx;
		coord_t sy;
		coord_t tx;
		coord_t ty;
		int     gap;
		bit     drain;
	} grid_req_t;

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t tx;
		coord_t ty;
		logic   vis;
	} sight_result_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_type = REQ_WRITE;
	coord_t cell_x = '0;
	coord_t cell_y = '0;
	logic   cell_blocked = 1'b0;
	coord_t src_x = '0;
	coord_t src_y = '0;
	coord_t dst_x = '0;
	coord_t dst_y = '0;
	logic   rsp_stall = 1'b0;
	logic   req_stall;
	logic   rsp_valid;
	logic   visible;

	grid_req_t     pending_reqs[$];
	sight_result_t sight_expected[$];
	grid_req_t     drive_item;
	sight_result_t seen_item;
	bit            blocked_cells [0:GRID_WIDTH_DEF*GRID_HEIGHT_DEF-1];
	int            gap_count = 0;
	int            stall_left = 0;
	int            quiet_left = 0;
	int            idle_cycles = 0;
	int            error_count = 0;

	grid_line_of_sight_walker #(
		.GRID_WIDTH(GRID_WIDTH_DEF),
		.GRID_HEIGHT(GRID_HEIGHT_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.cell_blocked(cell_blocked),
		.src_x(src_x),
		.src_y(src_y),
		.dst_x(dst_x),
		.dst_y(dst_y),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.visible(visible)
	);

	always #4 clk = ~clk;

	// Walk from source to destination; the source cell is skipped, the
	// destination is tested.
	function automatic logic walk_visible(coord_t sx, coord_t sy, coord_t tx, coord_t ty);
		int stx, sty, nx, ny, px, py, ix, iy, d;
		logic vis;
		stx = (tx > sx) ? 1 : ((tx < sx) ? -1 : 0);
		sty = (ty > sy) ? 1 : ((ty < sy) ? -1 : 0);
		nx = (tx > sx) ? int'(tx) - int'(sx) : int'(sx) - int'(tx);
		ny = (ty > sy) ? int'(ty) - int'(sy) : int'(sy) - int'(ty);
		px = sx;
		py = sy;
		ix = 0;
		iy = 0;
		vis = 1'b1;
		while (vis && (ix < nx || iy < ny)) begin
			d = (1 + 2 * iy) * nx - (1 + 2 * ix) * ny;
			if (d == 0) begin
				px += stx;
				py += sty;
				ix++;
				iy++;
			end else if (d < 0) begin
				py += sty;
				iy++;
			end else begin
				px += stx;
				ix++;
			end
			if (blocked_cells[py * GRID_WIDTH_DEF + px])
				vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 45);
	endfunction

	task automatic add_write(int x, int y, logic b, int gap, bit drain);
		grid_req_t it;
		it.rtype = REQ_WRITE;
		it.cx = coord_t'(x);
		it.cy = coord_t'(y);
		it.cb = b;
		it.sx = coord_t'($urandom);
		it.sy = coord_t'($urandom);
		it.tx = coord_t'($urandom);
		it.ty = coord_t'($urandom);
		it.gap = gap;
		it.drain = drain;
		pending_reqs = {pending_reqs, it};
	endtask

	task automatic add_query(int sx, int sy, int tx, int ty, int gap, bit drain);
		grid_req_t it;
		it.rtype = REQ_QUERY;
		it.cx = coord_t'($urandom);
		it.cy = coord_t'($urandom);
		it.cb = 1'($urandom);
		it.sx = coord_t'(sx);
		it.sy = coord_t'(sy);
		it.tx = coord_t'(tx);
		it.ty = coord_t'(ty);
		it.gap = gap;
		it.drain = drain;
		pending_reqs = {pending_reqs, it};
	endtask

	// Request driver: updates the grid copy on each accepted write and queues the
	// expected answer on each accepted query.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_count = 0;
		end else begin
			if (req_valid && !req_stall) begin
				if (drive_item.rtype == REQ_WRITE)
					blocked_cells[drive_item.cy * GRID_WIDTH_DEF + drive_item.cx] =
						drive_item.cb;
				else
					sight_expected = {sight_expected,
						sight_result_t'{drive_item.sx, drive_item.sy,
						drive_item.tx, drive_item.ty,
						walk_visible(drive_item.sx, drive_item.sy,
							drive_item.tx, drive_item.ty)}};
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() == 0) begin
					req_valid <= 1'b0;
				end else if (gap_count < pending_reqs[0].gap ||
						(pending_reqs[0].drain && sight_expected.size() != 0)) begin
					gap_count++;
					req_valid <= 1'b0;
				end else begin
					drive_item = pending_reqs.pop_front();
					gap_count = 0;
					req_valid <= 1'b1;
					req_type <= drive_item.rtype;
					cell_x <= drive_item.cx;
					cell_y <= drive_item.cy;
					cell_blocked <= drive_item.cb;
					src_x <= drive_item.sx;
					src_y <= drive_item.sy;
					dst_x <= drive_item.tx;
					dst_y <= drive_item.ty;
				end
			end
		end
	end

	// Result monitor and random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (sight_expected.size() == 0) begin
					$display("%0t: unexpected result transfer: expected none, got visible=%0b",
						$time, visible);
					error_count++;
				end else begin
					seen_item = sight_expected.pop_front();
					if (visible !== seen_item.vis) begin
						$display("%0t: visible (%0d,%0d)->(%0d,%0d): expected %0b, got %0b",
							$time, seen_item.sx, seen_item.sy, seen_item.tx,
							seen_item.ty, seen_item.vis, visible);
						error_count++;
					end
				end
			end
			if (quiet_left > 0) begin
				quiet_left--;
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 999) < 3) begin
				quiet_left = $urandom_range(200, 600);
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
					: $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int issued, w, ox, oy, p_block, ep_len, k;
		bit quiet;
		for (int n = 0; n < GRID_WIDTH_DEF * GRID_HEIGHT_DEF; n++)
			blocked_cells[n] = 1'b0;

		// directed: empty-grid walks, endpoints, same-cell queries, walks into written blockers
		add_query(0, 0, 0, 0, 0, 0);
		add_query(0, 0, 63, 63, 0, 0);
		add_query(63, 0, 0, 63, 1, 0);
		add_write(63, 63, 1'b1, 0, 0);
		add_query(0, 0, 63, 63, 0, 0);
		add_query(63, 63, 0, 0, 0, 0);
		add_query(63, 63, 63, 63, 0, 0);
		add_write(0, 63, 1'b1, 0, 0);
		add_query(0, 0, 0, 63, 0, 0);
		add_query(0, 63, 0, 0, 2, 0);
		add_write(32, 32, 1'b1, 0, 0);
		add_query(0, 0, 63, 63, 0, 0);
		add_query(10, 10, 60, 50, 0, 0);
		add_write(63, 0, 1'b1, 0, 0);
		add_query(0, 0, 63, 0, 0, 0);
		add_query(5, 0, 6, 63, 0, 0);
		add_query(0, 5, 63, 6, 0, 0);
		add_write(63, 63, 1'b0, 0, 0);
		add_write(0, 63, 1'b0, 0, 0);
		add_write(32, 32, 1'b0, 0, 0);
		add_write(63, 0, 1'b0, 0, 0);
		add_query(0, 0, 63, 63, 0, 0);
		add_query(63, 0, 0, 0, 0, 0);

		// random: episodes in a window of the grid so blockers get dense there
		issued = 0;
		k = 0;
		while (issued < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: w = 4;
				1: w = 8;
				2: w = 16;
				default: w = 64;
			endcase
			ox = $urandom_range(0, 64 - w);
			oy = $urandom_range(0, 64 - w);
			p_block = $urandom_range(20, 90);
			quiet = ($urandom_range(0, 5) == 0);
			ep_len = $urandom_range(15, 40);
			for (int i = 0; i < ep_len; i++) begin
				if ($urandom_range(0, 99) < 8)
					add_query($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 63),
						pick_gap(quiet), 0);
				else if ($urandom_range(0, 99) < 40)
					add_write(ox + $urandom_range(0, w - 1), oy + $urandom_range(0, w - 1),
						$urandom_range(0, 99) < p_block, pick_gap(quiet), 0);
				else
					add_query(ox + $urandom_range(0, w - 1), oy + $urandom_range(0, w - 1),
						ox + $urandom_range(0, w - 1), oy + $urandom_range(0, w - 1),
						pick_gap(quiet), i == 0 && k % 5 == 0);
				issued++;
			end
			k++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid || sight_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sight_expected.size() != 0) begin
			$display("%0t: %0d results still expected, none arrived",
				$time, sight_expected.size());
			error_count++;
		end
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: grid_line_of_sight_walker.f
rtl/lossw_pkg.sv
rtl/lossw_map.sv
rtl/lossw_walk.sv
rtl/grid_line_of_sight_walker.sv
dv/testbench.sv
